// ===== design/rar_pkg.sv =====
package rar_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  // Quotient bits resolved per divider cycle.
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STEPS  = DATA_WIDTH / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MUL_DEN = 2'd0,
    MUL_NUM = 2'd1,
    MUL_ALT = 2'd2
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_REM = 2'd0,
    DIV_QN  = 2'd1,
    DIV_QD  = 2'd2
  } div_sel_e;

  typedef struct packed {
    func_e                  func;
    logic [DATA_WIDTH-1:0]  a_num;
    logic [DATA_WIDTH-1:0]  a_den;
    logic [DATA_WIDTH-1:0]  b_num;
    logic [DATA_WIDTH-1:0]  b_den;
  } in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0]  res_num;
    logic [DATA_WIDTH-1:0]  res_den;
    logic                   overflow;
    logic                   zero_divisor;
  } out_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     add_en;
    logic     gcd_init;
    logic     gcd_step;
    logic     div_start;
    div_sel_e div_sel;
    logic     q_num_wr;
    logic     q_den_wr;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic  x_zero;
    logic  y_zero;
    logic  div_done;
    func_e func;
  } status_t;

  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
    mag = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== design/rar_div.sv =====
module rar_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rar_pkg::DATA_WIDTH-1:0]   dividend_i,
  input  logic [rar_pkg::DATA_WIDTH-1:0]   divisor_i,
  output logic                             done_o,
  output logic [rar_pkg::DATA_WIDTH-1:0]   quo_o,
  output logic [rar_pkg::DATA_WIDTH-1:0]   rem_o
);

  localparam int unsigned W = rar_pkg::DATA_WIDTH;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [rar_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]                  quo_q, quo_d;
  logic [W-1:0]                  rem_q, rem_d;
  logic [W-1:0]                  dvs_q, dvs_d;
  logic [W-1:0]                  step_r, step_q;

  // Restoring division, DIV_BITS quotient bits per cycle while busy.
  always_comb begin
    logic [W:0] t;
    step_r = rem_q;
    step_q = quo_q;
    for (int i = 0; i < int'(rar_pkg::DIV_BITS); i++) begin
      t      = {step_r, step_q[W-1]};
      step_q = {step_q[W-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        t         = t - {1'b0, dvs_q};
        step_q[0] = 1'b1;
      end
      step_r = t[W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = rar_pkg::DIV_CNT_W'(rar_pkg::DIV_STEPS);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = step_q;
      rem_d = step_r;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rar_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with empty count");

endmodule

// ===== design/rar_dp.sv =====
module rar_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rar_pkg::in_t     in_data_i,
  input  rar_pkg::cmd_t    cmd_i,
  output rar_pkg::status_t status_o,
  output rar_pkg::out_t    out_data_o
);

  localparam int unsigned W = rar_pkg::DATA_WIDTH;

  rar_pkg::in_t  in_q;
  rar_pkg::out_t out_q;
  logic [W-1:0]  num_q, den_q, m2_q, x_q, y_q;
  logic          ov_q;

  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] prod;
  logic           mul_ov;
  logic [W-1:0]   sum;
  logic           sum_ov;
  logic [W-1:0]   dvd, dvs;
  logic           div_done;
  logic [W-1:0]   quo, rem;
  logic [W-1:0]   rem_s;
  logic           q_neg;
  logic [W-1:0]   q_res;
  logic           q_ov;

  always_comb begin
    unique case (cmd_i.mul_sel)
      rar_pkg::MUL_DEN: begin
        mul_a = in_q.a_den;
        mul_b = (in_q.func == rar_pkg::FUNC_DIV) ? in_q.b_num : in_q.b_den;
      end
      rar_pkg::MUL_NUM: begin
        mul_a = in_q.a_num;
        mul_b = (in_q.func == rar_pkg::FUNC_MUL) ? in_q.b_num : in_q.b_den;
      end
      rar_pkg::MUL_ALT: begin
        mul_a = in_q.a_den;
        mul_b = in_q.b_num;
      end
      default: begin
        mul_a = in_q.a_den;
        mul_b = in_q.b_den;
      end
    endcase
  end

  assign prod   = (2*W)'($signed(mul_a) * $signed(mul_b));
  // The product fits when its upper half is a copy of the sign bit.
  assign mul_ov = !((&prod[2*W-1:W-1]) || !(|prod[2*W-1:W-1]));

  always_comb begin
    if (in_q.func == rar_pkg::FUNC_SUB) begin
      sum    = num_q - m2_q;
      sum_ov = (num_q[W-1] != m2_q[W-1]) && (sum[W-1] != num_q[W-1]);
    end else begin
      sum    = num_q + m2_q;
      sum_ov = (num_q[W-1] == m2_q[W-1]) && (sum[W-1] != num_q[W-1]);
    end
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      rar_pkg::DIV_REM: begin
        dvd = rar_pkg::mag(y_q);
        dvs = rar_pkg::mag(x_q);
      end
      rar_pkg::DIV_QN: begin
        dvd = rar_pkg::mag(num_q);
        dvs = rar_pkg::mag(y_q);
      end
      rar_pkg::DIV_QD: begin
        dvd = rar_pkg::mag(den_q);
        dvs = rar_pkg::mag(y_q);
      end
      default: begin
        dvd = rar_pkg::mag(y_q);
        dvs = rar_pkg::mag(x_q);
      end
    endcase
  end

  rar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // The remainder takes the sign of the dividend.
  assign rem_s = y_q[W-1] ? (~rem + 1'b1) : rem;

  // The divisor y_q holds the common divisor during both final divisions.
  always_comb begin
    q_neg = (cmd_i.q_num_wr ? num_q[W-1] : den_q[W-1]) ^ y_q[W-1];
    q_res = q_neg ? (~quo + 1'b1) : quo;
    q_ov  = !q_neg && quo[W-1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        rar_pkg::MUL_DEN: den_q <= prod[W-1:0];
        rar_pkg::MUL_NUM: num_q <= prod[W-1:0];
        default:          m2_q  <= prod[W-1:0];
      endcase
    end else if (cmd_i.add_en) begin
      num_q <= sum;
    end else if (cmd_i.q_num_wr) begin
      num_q <= q_res;
    end else if (cmd_i.q_den_wr) begin
      den_q <= q_res;
    end
    if (cmd_i.load_in) begin
      ov_q <= 1'b0;
    end else if (cmd_i.mul_en) begin
      ov_q <= ov_q | mul_ov;
    end else if (cmd_i.add_en) begin
      ov_q <= ov_q | sum_ov;
    end else if (cmd_i.q_num_wr || cmd_i.q_den_wr) begin
      ov_q <= ov_q | q_ov;
    end
    if (cmd_i.gcd_init) begin
      x_q <= num_q;
      y_q <= den_q;
    end else if (cmd_i.gcd_step) begin
      y_q <= x_q;
      x_q <= rem_s;
    end
    if (cmd_i.out_load) begin
      out_q.res_num      <= num_q;
      out_q.res_den      <= den_q;
      out_q.overflow     <= ov_q;
      out_q.zero_divisor <= (y_q == '0);
    end
  end

  assign status_o.x_zero   = (x_q == '0);
  assign status_o.y_zero   = (y_q == '0);
  assign status_o.div_done = div_done;
  assign status_o.func     = in_q.func;
  assign out_data_o        = out_q;

endmodule

// ===== design/rar_ctrl.sv =====
module rar_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  rar_pkg::status_t status_i,
  output rar_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MUL0 = 10'b00_0000_0010,
    S_MUL1 = 10'b00_0000_0100,
    S_MUL2 = 10'b00_0000_1000,
    S_ADD  = 10'b00_0001_0000,
    S_INIT = 10'b00_0010_0000,
    S_CHK  = 10'b00_0100_0000,
    S_REM  = 10'b00_1000_0000,
    S_QNUM = 10'b01_0000_0000,
    S_QDEN = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !done_q) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rar_pkg::MUL_DEN;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rar_pkg::MUL_NUM;
        if (status_i.func == rar_pkg::FUNC_ADD || status_i.func == rar_pkg::FUNC_SUB) begin
          state_d = S_MUL2;
        end else begin
          state_d = S_INIT;
        end
      end
      S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rar_pkg::MUL_ALT;
        state_d       = S_ADD;
      end
      S_ADD: begin
        cmd_o.add_en = 1'b1;
        state_d      = S_INIT;
      end
      S_INIT: begin
        cmd_o.gcd_init = 1'b1;
        state_d        = S_CHK;
      end
      S_CHK: begin
        if (!status_i.x_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = rar_pkg::DIV_REM;
          state_d         = S_REM;
        end else if (status_i.y_zero) begin
          // Both parts are zero: the result goes out unreduced.
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = rar_pkg::DIV_QN;
          state_d         = S_QNUM;
        end
      end
      S_REM: begin
        cmd_o.div_sel = rar_pkg::DIV_REM;
        if (status_i.div_done) begin
          cmd_o.gcd_step = 1'b1;
          state_d        = S_CHK;
        end
      end
      S_QNUM: begin
        cmd_o.div_sel = rar_pkg::DIV_QN;
        if (status_i.div_done) begin
          cmd_o.q_num_wr  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = rar_pkg::DIV_QD;
          state_d         = S_QDEN;
        end
      end
      S_QDEN: begin
        cmd_o.div_sel = rar_pkg::DIV_QD;
        if (status_i.div_done) begin
          cmd_o.q_den_wr = 1'b1;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // A finished result moves into the output register once it is free.
    if (done_q && (!out_valid_q || !out_stall_i)) begin
      cmd_o.out_load = 1'b1;
      done_d         = 1'b0;
    end
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      done_q      <= done_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE) || done_q;
  assign out_valid_o = out_valid_q;

  a_load_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> done_q && state_q == S_IDLE)
    else $error("output loaded without a finished result");
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |-> !done_q) else $error("new transaction over a pending result");
  a_start_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == S_REM || state_q == S_QNUM || state_q == S_QDEN))
    else $error("division started without a wait state");

endmodule

// ===== design/rational_arithmetic_reduce.sv =====
// Combines two signed fractions by add, subtract, multiply or divide and
// reduces the result by a common divisor found with truncating Euclid
// steps; products and sums wrap, setting overflow, and a zero divisor
// leaves the result unreduced with zero_divisor set. One transaction is
// processed at a time. It runs through acceptance, the products and
// setup, the Euclid remainder steps, the check and, unless both parts
// are zero, the two final divisions, and hands the result to the output
// register. The divider, shared by the remainder steps and the final
// divisions, resolves two quotient bits per cycle. A finished result
// waits in an output register while the next transaction is accepted.
module rational_arithmetic_reduce (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rar_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rar_pkg::out_t out_data_o
);

  rar_pkg::cmd_t    cmd;
  rar_pkg::status_t status;

  rar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rar_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = rar_pkg::DATA_WIDTH;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 900;

  typedef logic [W-1:0] word_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  rar_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  rar_pkg::out_t out_data_o;

  rar_pkg::in_t  pending_q[$];
  rar_pkg::out_t fraction_q[$];
  bit    stimulus_done;
  bit    failed;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_phase;

  rational_arithmetic_reduce DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Signed helpers on 64-bit carriers; values are sign-extended DATA_WIDTH words.
  function automatic longint sext(input word_t v);
    sext = longint'($signed(v));
  endfunction

  function automatic bit fits(input longint v);
    longint lo, hi;
    lo = -(longint'(1) <<< (W - 1));
    hi = (longint'(1) <<< (W - 1)) - 1;
    fits = (v >= lo) && (v <= hi);
  endfunction

  function automatic word_t mul_wrap(input word_t x, input word_t y, inout bit ov);
    longint p;
    p = sext(x) * sext(y);
    if (!fits(p)) ov = 1'b1;
    mul_wrap = word_t'(p);
  endfunction

  function automatic word_t add_wrap(input word_t x, input word_t y, input bit sub,
                                     inout bit ov);
    longint s;
    s = sub ? sext(x) - sext(y) : sext(x) + sext(y);
    if (!fits(s)) ov = 1'b1;
    add_wrap = word_t'(s);
  endfunction

  function automatic word_t div_trunc(input word_t y, input word_t x, inout bit ov);
    longint q;
    q = sext(y) / sext(x);
    if (!fits(q)) ov = 1'b1;
    div_trunc = word_t'(q);
  endfunction

  function automatic rar_pkg::out_t reduce_fraction(input rar_pkg::in_t it);
    rar_pkg::out_t r;
    bit    ov;
    word_t num, den, x, y, t;
    ov = 1'b0;
    num = '0;
    den = '0;
    case (it.func)
      rar_pkg::FUNC_ADD, rar_pkg::FUNC_SUB: begin
        den = mul_wrap(it.a_den, it.b_den, ov);
        num = add_wrap(mul_wrap(it.a_num, it.b_den, ov),
                       mul_wrap(it.a_den, it.b_num, ov),
                       it.func == rar_pkg::FUNC_SUB, ov);
      end
      rar_pkg::FUNC_MUL: begin
        den = mul_wrap(it.a_den, it.b_den, ov);
        num = mul_wrap(it.a_num, it.b_num, ov);
      end
      default: begin
        num = mul_wrap(it.a_num, it.b_den, ov);
        den = mul_wrap(it.a_den, it.b_num, ov);
      end
    endcase
    x = num;
    y = den;
    while (x != '0) begin
      t = word_t'(sext(y) % sext(x));
      y = x;
      x = t;
    end
    r.zero_divisor = (y == '0);
    if (y != '0) begin
      num = div_trunc(num, y, ov);
      den = div_trunc(den, y, ov);
    end
    r.res_num = num;
    r.res_den = den;
    r.overflow = ov;
    return r;
  endfunction

  function automatic word_t rand_word(input int unsigned kind);
    case (kind)
      0: rand_word = word_t'($urandom_range(0, 40)) - word_t'(20);
      1: rand_word = word_t'($urandom_range(0, 200000)) - word_t'(100000);
      2: rand_word = {W{1'b0}} | W'($urandom) >> $urandom_range(0, W - 1);
      default: rand_word = W'($urandom);
    endcase
    if (kind == 2 && $urandom_range(0, 1)) rand_word = -rand_word;
  endfunction

  function automatic rar_pkg::in_t make_item(input rar_pkg::func_e f, input word_t an,
                                             input word_t ad, input word_t bn,
                                             input word_t bd);
    rar_pkg::in_t it;
    it.func = f;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  initial begin
    word_t mn, mx, c;
    rar_pkg::in_t it;
    int unsigned k;
    mn = {1'b1, {(W-1){1'b0}}};
    mx = {1'b0, {(W-1){1'b1}}};
    for (int f = 0; f < 4; f++) begin
      pending_q.push_back(make_item(rar_pkg::func_e'(f), 1, 2, 1, 3));
      pending_q.push_back(make_item(rar_pkg::func_e'(f), mx, mx, mn, mn));
      pending_q.push_back(make_item(rar_pkg::func_e'(f), -3, 4, 5, -6));
    end
    // Both parts zero: the common divisor is zero and the result stays unreduced.
    pending_q.push_back(make_item(rar_pkg::FUNC_MUL, 0, 0, 5, 7));
    pending_q.push_back(make_item(rar_pkg::FUNC_ADD, 0, 0, 0, 0));
    pending_q.push_back(make_item(rar_pkg::FUNC_DIV, 0, 1, 0, 1));
    // Zero denominators go straight through the arithmetic.
    pending_q.push_back(make_item(rar_pkg::FUNC_ADD, 3, 0, 5, 7));
    pending_q.push_back(make_item(rar_pkg::FUNC_DIV, 3, 4, 0, 9));
    // Negative divisor makes both parts flip sign.
    pending_q.push_back(make_item(rar_pkg::FUNC_MUL, 2, -1, 3, 1));
    // Most negative value divided by minus one.
    pending_q.push_back(make_item(rar_pkg::FUNC_MUL, mn, -1, 1, 1));
    pending_q.push_back(make_item(rar_pkg::FUNC_DIV, mn, 1, -1, 1));
    pending_q.push_back(make_item(rar_pkg::FUNC_SUB, mn, 1, mx, 1));
    pending_q.push_back(make_item(rar_pkg::FUNC_MUL, '1, '1, '1, '1));
    pending_q.push_back(make_item(rar_pkg::FUNC_ADD, 1, 1, 1, 1));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      k = $urandom_range(0, 9);
      it.func = rar_pkg::func_e'($urandom_range(0, 3));
      it.a_num = rand_word(k < 4 ? 0 : k < 7 ? 1 : k < 9 ? 2 : 3);
      it.a_den = rand_word($urandom_range(0, 3));
      it.b_num = rand_word($urandom_range(0, 3));
      it.b_den = rand_word($urandom_range(0, 3));
      if ($urandom_range(0, 15) == 0) begin
        c = rand_word(1);
        it.a_num = c;
        it.b_num = c;
      end
      pending_q.push_back(it);
    end
    stimulus_done = 1'b1;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: bursts of transactions separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!in_valid_i || !in_stall_o) begin
        // The front of the queue is always the item on the input or the next to drive.
        if (in_valid_i) begin
          fraction_q.push_back(reduce_fraction(in_data_i));
          void'(pending_q.pop_front());
        end
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_q[0];
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor, with a receiver that stalls on a slowly changing pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    rar_pkg::out_t exp;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_phase <= 0;
      idle_cycles <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case (stall_phase[11:10])
        2'd0: out_stall_i <= 1'b0;
        2'd1: out_stall_i <= $urandom_range(0, 3) == 0;
        2'd2: out_stall_i <= stall_phase[4];
        default: out_stall_i <= $urandom_range(0, 1);
      endcase
      if (out_valid_o && !out_stall_i) begin
        if (fraction_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_o);
          failed = 1'b1;
        end else begin
          exp = fraction_q.pop_front();
          if (out_data_o !== exp) begin
            $display("%0t: expected num %0d den %0d ov %b zd %b, got %0d %0d %b %b",
                     $time, $signed(exp.res_num), $signed(exp.res_den), exp.overflow,
                     exp.zero_divisor, $signed(out_data_o.res_num),
                     $signed(out_data_o.res_den), out_data_o.overflow,
                     out_data_o.zero_divisor);
            failed = 1'b1;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("rational_arithmetic_reduce: mismatch");
        $finish;
      end
      if (stimulus_done && pending_q.size() == 0 && !in_valid_i
          && fraction_q.size() == 0) begin
        repeat (1000) @(posedge clk_i);
        if (!failed) begin
          $display("rational_arithmetic_reduce: match");
        end else begin
          $display("rational_arithmetic_reduce: mismatch");
        end
        $finish;
      end
    end
  end
endmodule

// ===== files.f =====
design/rar_pkg.sv
design/rar_div.sv
design/rar_dp.sv
design/rar_ctrl.sv
design/rational_arithmetic_reduce.sv
tb/sv/tb.sv
